// ===== rtl/iwg_pkg.sv =====
// iwg_pkg: shared types and constants of the im2col window gather block
// no dependencies; imported by iwg_addr_gen, im2col_window_gather and the testbench
`default_nettype none

package iwg_pkg;

  localparam int HEIGHT_W  = 9;
  localparam int PAD_W     = 4;
  localparam int STEP_W    = 4;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int LADDR_W   = 12;
  localparam int WORD_W    = 32;
  localparam int CH_W      = 4;
  localparam int TAP_W     = 4;
  localparam int POS_W     = 8;
  localparam int CALC_W    = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_HEIGHT  = 3'd0,
    REG_IMAGE_WIDTH   = 3'd1,
    REG_PAD_ROWS      = 3'd2,
    REG_PAD_COLS      = 3'd3,
    REG_STRIDE_ROWS   = 3'd4,
    REG_STRIDE_COLS   = 3'd5,
    REG_DILATION_ROWS = 3'd6,
    REG_DILATION_COLS = 3'd7
  } iwg_reg_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] image_height;
    logic [HEIGHT_W-1:0] image_width;
    logic [PAD_W-1:0]    pad_rows;
    logic [PAD_W-1:0]    pad_cols;
    logic [STEP_W-1:0]   stride_rows;
    logic [STEP_W-1:0]   stride_cols;
    logic [STEP_W-1:0]   dilation_rows;
    logic [STEP_W-1:0]   dilation_cols;
  } iwg_cfg_t;

  typedef struct packed {
    logic              vld;
    logic              fetch;
    logic              pad;
    logic [CALC_W-1:0] addr;
  } iwg_req_t;

endpackage

`default_nettype wire

// ===== rtl/iwg_ram.sv =====
// iwg_ram: generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module iwg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/iwg_addr_gen.sv =====
// iwg_addr_gen: three-stage source position and flat address pipeline
// depends on iwg_pkg
`default_nettype none

module iwg_addr_gen (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire iwg_pkg::iwg_cfg_t             cfg,
  input  wire logic                          in_vld,
  input  wire logic                          in_fetch,
  input  wire logic [iwg_pkg::LADDR_W-1:0]   load_address,
  input  wire logic [iwg_pkg::WORD_W-1:0]    load_value,
  input  wire logic [iwg_pkg::CH_W-1:0]      channel,
  input  wire logic [iwg_pkg::TAP_W-1:0]     kernel_row,
  input  wire logic [iwg_pkg::TAP_W-1:0]     kernel_col,
  input  wire logic [iwg_pkg::POS_W-1:0]     out_row,
  input  wire logic [iwg_pkg::POS_W-1:0]     out_col,
  output iwg_pkg::iwg_req_t                  req,
  output logic      [iwg_pkg::WORD_W-1:0]    req_value
);
  import iwg_pkg::*;

  localparam int PROD_W = POS_W + STEP_W;
  localparam int TPRD_W = TAP_W + STEP_W;
  localparam int CHH_W  = CH_W + HEIGHT_W;
  localparam int POSN_W = PROD_W + 2;
  localparam int BASE_W = CHH_W + 1;

  // stage 1: products
  logic                  s1_vld_r, s1_fetch_r;
  logic [LADDR_W-1:0]    s1_la_r;
  logic [WORD_W-1:0]     s1_lv_r;
  logic [PROD_W-1:0]     s1_rprod_r, s1_cprod_r;
  logic [TPRD_W-1:0]     s1_rtap_r, s1_ctap_r;
  logic [CHH_W-1:0]      s1_chh_r;

  // stage 2: bounds and row base
  logic                  s2_vld_r, s2_fetch_r, s2_pad_r;
  logic [LADDR_W-1:0]    s2_la_r;
  logic [WORD_W-1:0]     s2_lv_r;
  logic [BASE_W-1:0]     s2_base_r;
  logic [HEIGHT_W-1:0]   s2_col_r;

  // stage 3: flat address
  logic                  s3_vld_r, s3_fetch_r, s3_pad_r;
  logic [CALC_W-1:0]     s3_addr_r;
  logic [WORD_W-1:0]     s3_lv_r;

  logic [POSN_W-1:0]     row_nxt, col_nxt;
  logic                  pad_nxt;
  logic [BASE_W-1:0]     base_nxt;
  logic [CALC_W-1:0]     addr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_fetch_r <= in_fetch;
      s1_la_r    <= load_address;
      s1_lv_r    <= load_value;
      s1_rprod_r <= PROD_W'(out_row) * PROD_W'(cfg.stride_rows);
      s1_cprod_r <= PROD_W'(out_col) * PROD_W'(cfg.stride_cols);
      s1_rtap_r  <= TPRD_W'(kernel_row) * TPRD_W'(cfg.dilation_rows);
      s1_ctap_r  <= TPRD_W'(kernel_col) * TPRD_W'(cfg.dilation_cols);
      s1_chh_r   <= CHH_W'(channel) * CHH_W'(cfg.image_height);

      s2_fetch_r <= s1_fetch_r;
      s2_la_r    <= s1_la_r;
      s2_lv_r    <= s1_lv_r;
      s2_pad_r   <= pad_nxt;
      s2_base_r  <= base_nxt;
      s2_col_r   <= col_nxt[HEIGHT_W-1:0];

      s3_fetch_r <= s2_fetch_r;
      s3_pad_r   <= s2_pad_r;
      s3_lv_r    <= s2_lv_r;
      s3_addr_r  <= addr_nxt;
    end
  end

  always_comb begin
    row_nxt  = POSN_W'(s1_rprod_r) + POSN_W'(s1_rtap_r) - POSN_W'(cfg.pad_rows);
    col_nxt  = POSN_W'(s1_cprod_r) + POSN_W'(s1_ctap_r) - POSN_W'(cfg.pad_cols);
    // sign bit set means above or left of the image
    pad_nxt  = row_nxt[POSN_W-1] || col_nxt[POSN_W-1]
            || (row_nxt >= POSN_W'(cfg.image_height))
            || (col_nxt >= POSN_W'(cfg.image_width));
    base_nxt = BASE_W'(s1_chh_r) + BASE_W'(row_nxt[HEIGHT_W-1:0]);
    if (s2_fetch_r) begin
      addr_nxt = CALC_W'(s2_base_r) * CALC_W'(cfg.image_width) + CALC_W'(s2_col_r);
    end else begin
      addr_nxt = CALC_W'(s2_la_r);
    end
  end

  always_comb begin
    req.vld   = s3_vld_r;
    req.fetch = s3_fetch_r;
    req.pad   = s3_pad_r;
    req.addr  = s3_addr_r;
  end

  assign req_value = s3_lv_r;

endmodule

`default_nettype wire

// ===== rtl/im2col_window_gather.sv =====
// im2col_window_gather: top level, config registers, image store access and result register
// depends on iwg_pkg, iwg_addr_gen, iwg_ram
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    kind, load address/value, fetch operands
//   out      output     out_valid / out_stall  element value, padding flag, range error flag
//   cfg      input      cfg_wr_en              cfg_index, cfg_wdata
//
// one word taken per cycle unless stalled; fetch results pass s1-s3 and the result reg
// three address stages feed at most one single-port image store access per word
// out_stall on a held result freezes the whole pipeline and raises in_stall
// reset clears control and config registers only; the image store is not cleared
`default_nettype none

module im2col_window_gather #(
  parameter int IMAGE_WORDS = 4096,
  parameter int DATA_BITS   = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [iwg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [iwg_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_kind,
  input  wire logic [iwg_pkg::LADDR_W-1:0]     in_load_address,
  input  wire logic [iwg_pkg::WORD_W-1:0]      in_load_value,
  input  wire logic [iwg_pkg::CH_W-1:0]        in_channel,
  input  wire logic [iwg_pkg::TAP_W-1:0]       in_kernel_row,
  input  wire logic [iwg_pkg::TAP_W-1:0]       in_kernel_col,
  input  wire logic [iwg_pkg::POS_W-1:0]       in_out_row,
  input  wire logic [iwg_pkg::POS_W-1:0]       in_out_col,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [iwg_pkg::WORD_W-1:0]      out_element_value,
  output logic                                 out_is_padding,
  output logic                                 out_range_error
);
  import iwg_pkg::*;

  localparam int ADDR_W = $clog2(IMAGE_WORDS);
  localparam logic [CALC_W:0] STORE_LIMIT = (CALC_W+1)'(IMAGE_WORDS);

  iwg_cfg_t            cfg_r;
  iwg_req_t            req;
  logic [WORD_W-1:0]   req_value;
  logic                adv;
  logic                in_store;
  logic                ram_en, ram_we;
  logic [DATA_BITS-1:0] rdata;
  logic                out_valid_r, out_pad_r, out_err_r;
  logic [WORD_W-1:0]   elem;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_height  <= HEIGHT_W'(1);
      cfg_r.image_width   <= HEIGHT_W'(1);
      cfg_r.pad_rows      <= '0;
      cfg_r.pad_cols      <= '0;
      cfg_r.stride_rows   <= STEP_W'(1);
      cfg_r.stride_cols   <= STEP_W'(1);
      cfg_r.dilation_rows <= STEP_W'(1);
      cfg_r.dilation_cols <= STEP_W'(1);
    end else if (cfg_wr_en) begin
      case (iwg_reg_t'(cfg_index))
        REG_IMAGE_HEIGHT:  cfg_r.image_height  <= cfg_wdata[HEIGHT_W-1:0];
        REG_IMAGE_WIDTH:   cfg_r.image_width   <= cfg_wdata[HEIGHT_W-1:0];
        REG_PAD_ROWS:      cfg_r.pad_rows      <= cfg_wdata[PAD_W-1:0];
        REG_PAD_COLS:      cfg_r.pad_cols      <= cfg_wdata[PAD_W-1:0];
        REG_STRIDE_ROWS:   cfg_r.stride_rows   <= cfg_wdata[STEP_W-1:0];
        REG_STRIDE_COLS:   cfg_r.stride_cols   <= cfg_wdata[STEP_W-1:0];
        REG_DILATION_ROWS: cfg_r.dilation_rows <= cfg_wdata[STEP_W-1:0];
        REG_DILATION_COLS: cfg_r.dilation_cols <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  iwg_addr_gen u_addr_gen (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .cfg          (cfg_r),
    .in_vld       (in_valid),
    .in_fetch     (in_kind),
    .load_address (in_load_address),
    .load_value   (in_load_value),
    .channel      (in_channel),
    .kernel_row   (in_kernel_row),
    .kernel_col   (in_kernel_col),
    .out_row      (in_out_row),
    .out_col      (in_out_col),
    .req          (req),
    .req_value    (req_value)
  );

  assign in_store = ({1'b0, req.addr} < STORE_LIMIT);
  assign ram_we   = adv && req.vld && !req.fetch && in_store;
  assign ram_en   = ram_we || (adv && req.vld && req.fetch && !req.pad && in_store);

  iwg_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (IMAGE_WORDS)
  ) u_image_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (req.addr[ADDR_W-1:0]),
    .wdata (req_value[DATA_BITS-1:0]),
    .rdata (rdata)
  );

  // result register; data word sits in the ram read register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= req.vld && req.fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pad_r <= req.pad;
      out_err_r <= !req.pad && !in_store;
    end
  end

  always_comb begin
    elem = '0;
    if (!out_pad_r && !out_err_r) begin
      elem[DATA_BITS-1:0] = rdata;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_element_value = elem;
  assign out_is_padding    = out_pad_r;
  assign out_range_error   = out_err_r;

endmodule

`default_nettype wire

// ===== test/im2col_window_gather_tb.sv =====
// im2col_window_gather_tb: self-checking testbench for the im2col window gather block
// depends on iwg_pkg and im2col_window_gather; streams loads and fetches through ten
// geometry settings with random stalls and checks every gathered word against a predictor
`default_nettype none

module im2col_window_gather_tb;
  import iwg_pkg::*;

  localparam int IMAGE_WORDS   = 4096;
  localparam int PHASES        = 10;
  localparam int QUIET_PHASE   = 4;
  localparam int HOLDOFF_PHASE = 8;
  localparam int PAUSE_PHASE   = 9;
  localparam int HOLDOFF_LEN   = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int OUTSIDE_IMAGE = -1;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic {
    WORD_LOAD  = 1'b0,
    WORD_FETCH = 1'b1
  } word_kind_t;

  typedef struct packed {
    word_kind_t         kind;
    logic [LADDR_W-1:0] load_address;
    logic [WORD_W-1:0]  load_value;
    logic [CH_W-1:0]    channel;
    logic [TAP_W-1:0]   kernel_row;
    logic [TAP_W-1:0]   kernel_col;
    logic [POS_W-1:0]   out_row;
    logic [POS_W-1:0]   out_col;
  } gather_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] element_value;
    logic              is_padding;
    logic              range_error;
  } gather_result_t;

  class gather_scoreboard;
    iwg_cfg_t          cfg;
    logic [WORD_W-1:0] image_mem [IMAGE_WORDS];
    bit                written [IMAGE_WORDS];
    gather_result_t    expected_results [$];
    int                words_seen;
    int                results_seen;
    int                padded;
    int                beyond_store;
    int                failures;

    function new();
      cfg = {9'd1, 9'd1, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1};
      words_seen = 0;
      results_seen = 0;
      padded = 0;
      beyond_store = 0;
      failures = 0;
    endfunction

    function void set_reg(iwg_reg_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_IMAGE_HEIGHT:  cfg.image_height  = value;
        REG_IMAGE_WIDTH:   cfg.image_width   = value;
        REG_PAD_ROWS:      cfg.pad_rows      = value[PAD_W-1:0];
        REG_PAD_COLS:      cfg.pad_cols      = value[PAD_W-1:0];
        REG_STRIDE_ROWS:   cfg.stride_rows   = value[STEP_W-1:0];
        REG_STRIDE_COLS:   cfg.stride_cols   = value[STEP_W-1:0];
        REG_DILATION_ROWS: cfg.dilation_rows = value[STEP_W-1:0];
        REG_DILATION_COLS: cfg.dilation_cols = value[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // flat store address of the tapped element, or OUTSIDE_IMAGE when it lands in padding
    function int source_address(gather_word_t w);
      int h;
      int wd;
      int row;
      int col;
      h = int'(cfg.image_height);
      wd = int'(cfg.image_width);
      row = int'(w.out_row) * int'(cfg.stride_rows) - int'(cfg.pad_rows)
          + int'(w.kernel_row) * int'(cfg.dilation_rows);
      col = int'(w.out_col) * int'(cfg.stride_cols) - int'(cfg.pad_cols)
          + int'(w.kernel_col) * int'(cfg.dilation_cols);
      if (row < 0 || row >= h || col < 0 || col >= wd) return OUTSIDE_IMAGE;
      return (int'(w.channel) * h + row) * wd + col;
    endfunction

    function void note_word(gather_word_t w);
      gather_result_t want;
      int addr;
      words_seen++;
      if (w.kind == WORD_LOAD) begin
        image_mem[w.load_address] = w.load_value;
        written[w.load_address] = 1'b1;
        return;
      end
      addr = source_address(w);
      want = '0;
      if (addr == OUTSIDE_IMAGE) begin
        want.is_padding = 1'b1;
        padded++;
      end else if (addr >= IMAGE_WORDS) begin
        want.range_error = 1'b1;
        beyond_store++;
      end else begin
        want.element_value = image_mem[addr];
      end
      expected_results.push_back(want);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endfunction

    function void check_result(gather_result_t got);
      gather_result_t want;
      if (expected_results.size() == 0) begin
        flag($sformatf("unexpected result value=%h pad=%b err=%b",
                       got.element_value, got.is_padding, got.range_error));
        return;
      end
      want = expected_results.pop_front();
      results_seen++;
      if (got.element_value !== want.element_value)
        flag($sformatf("result %0d element_value expected %h got %h",
                       results_seen, want.element_value, got.element_value));
      if (got.is_padding !== want.is_padding)
        flag($sformatf("result %0d is_padding expected %b got %b",
                       results_seen, want.is_padding, got.is_padding));
      if (got.range_error !== want.range_error)
        flag($sformatf("result %0d range_error expected %b got %b",
                       results_seen, want.range_error, got.range_error));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = 1'b0;
  logic [LADDR_W-1:0] in_load_address = '0;
  logic [WORD_W-1:0]  in_load_value = '0;
  logic [CH_W-1:0]    in_channel = '0;
  logic [TAP_W-1:0]   in_kernel_row = '0;
  logic [TAP_W-1:0]   in_kernel_col = '0;
  logic [POS_W-1:0]   in_out_row = '0;
  logic [POS_W-1:0]   in_out_col = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [WORD_W-1:0]  out_element_value;
  logic               out_is_padding;
  logic               out_range_error;

  gather_scoreboard sb = new();
  bit               no_idle = 1'b0;
  int               holdoff_request = 0;
  int unsigned      cycle_count = 0;

  im2col_window_gather #(
    .IMAGE_WORDS(IMAGE_WORDS),
    .DATA_BITS(WORD_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_load_address(in_load_address),
    .in_load_value(in_load_value),
    .in_channel(in_channel),
    .in_kernel_row(in_kernel_row),
    .in_kernel_col(in_kernel_col),
    .in_out_row(in_out_row),
    .in_out_col(in_out_col),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_element_value(out_element_value),
    .out_is_padding(out_is_padding),
    .out_range_error(out_range_error)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still expected",
             cycle_count, sb.expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // result side: check accepted words, then pick the stall for the next cycle
  initial begin : result_side
    gather_result_t got;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.element_value = out_element_value;
        got.is_padding = out_is_padding;
        got.range_error = out_range_error;
        sb.check_result(got);
      end
      if (holdoff_request > 0) begin
        hold_left = holdoff_request;
        holdoff_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < 33);
      end
    end
  end

  task automatic send_word(input gather_word_t w);
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= w.kind;
    in_load_address <= w.load_address;
    in_load_value   <= w.load_value;
    in_channel      <= w.channel;
    in_kernel_row   <= w.kernel_row;
    in_kernel_col   <= w.kernel_col;
    in_out_row      <= w.out_row;
    in_out_col      <= w.out_col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  // a fetch that would read a never-loaded store word gets a load of that word first
  task automatic issue(input gather_word_t w);
    gather_word_t fill;
    int addr;
    if (w.kind == WORD_FETCH) begin
      addr = sb.source_address(w);
      if (addr >= 0 && addr < IMAGE_WORDS && !sb.written[addr]) begin
        fill = w;
        fill.kind = WORD_LOAD;
        fill.load_address = LADDR_W'(addr);
        fill.load_value = $urandom;
        send_word(fill);
      end
    end
    send_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input iwg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_setting(input iwg_cfg_t c);
    write_reg(REG_DILATION_COLS, CFG_W'(c.dilation_cols));
    write_reg(REG_DILATION_ROWS, CFG_W'(c.dilation_rows));
    write_reg(REG_STRIDE_COLS, CFG_W'(c.stride_cols));
    write_reg(REG_STRIDE_ROWS, CFG_W'(c.stride_rows));
    write_reg(REG_PAD_COLS, CFG_W'(c.pad_cols));
    write_reg(REG_PAD_ROWS, CFG_W'(c.pad_rows));
    write_reg(REG_IMAGE_WIDTH, c.image_width);
    write_reg(REG_IMAGE_HEIGHT, c.image_height);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic phase_plan(input int p, output iwg_cfg_t c, output int words);
    case (p)
      0: begin c = {9'd32, 9'd32, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}; words = 120; end
      1: begin c = {9'd8, 9'd8, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}; words = 250; end
      2: begin c = {9'd1, 9'd1, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1}; words = 100; end
      3: begin c = {9'd256, 9'd256, 4'd15, 4'd15, 4'd8, 4'd8, 4'd8, 4'd8}; words = 180; end
      4: begin c = {9'd16, 9'd16, 4'd2, 4'd3, 4'd2, 4'd2, 4'd2, 4'd3}; words = 300; end
      5: begin c = {9'd0, 9'd5, 4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1}; words = 60; end
      6: begin c = {9'd12, 9'd20, 4'd0, 4'd15, 4'd0, 4'd0, 4'd0, 4'd8}; words = 120; end
      7: begin c = {9'd511, 9'd511, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15}; words = 100; end
      8: begin c = {9'd64, 9'd64, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1}; words = 300; end
      default: begin c = {9'd5, 9'd7, 4'd3, 4'd2, 4'd3, 4'd1, 4'd1, 4'd4}; words = 200; end
    endcase
  endtask

  function automatic gather_word_t load_word(logic [LADDR_W-1:0] addr,
                                             logic [WORD_W-1:0] value);
    gather_word_t w;
    w.kind = WORD_LOAD;
    w.load_address = addr;
    w.load_value = value;
    w.channel = CH_W'($urandom);
    w.kernel_row = TAP_W'($urandom);
    w.kernel_col = TAP_W'($urandom);
    w.out_row = POS_W'($urandom);
    w.out_col = POS_W'($urandom);
    return w;
  endfunction

  function automatic gather_word_t fetch_word(logic [CH_W-1:0] ch, logic [TAP_W-1:0] kr,
                                              logic [TAP_W-1:0] kc, logic [POS_W-1:0] orow,
                                              logic [POS_W-1:0] ocol);
    gather_word_t w;
    w.kind = WORD_FETCH;
    w.load_address = LADDR_W'($urandom);
    w.load_value = $urandom;
    w.channel = ch;
    w.kernel_row = kr;
    w.kernel_col = kc;
    w.out_row = orow;
    w.out_col = ocol;
    return w;
  endfunction

  // runs under the 32x32, pad 1, unit step setting
  task automatic run_directed();
    issue(load_word(12'd0, 32'h0000_0000));
    issue(load_word(12'd4095, 32'hffff_ffff));
    issue(load_word(12'd33, 32'ha5a5_5a5a));
    issue(fetch_word(4'd0, 4'd1, 4'd1, 8'd0, 8'd0));
    issue(fetch_word(4'd0, 4'd0, 4'd0, 8'd0, 8'd0));
    issue(fetch_word(4'd0, 4'd2, 4'd2, 8'd0, 8'd0));
    // last word of the store, then its left neighbor
    issue(fetch_word(4'd3, 4'd1, 4'd1, 8'd31, 8'd31));
    issue(fetch_word(4'd3, 4'd1, 4'd0, 8'd31, 8'd31));
    // just past the right and bottom edges
    issue(fetch_word(4'd0, 4'd1, 4'd2, 8'd0, 8'd31));
    issue(fetch_word(4'd0, 4'd2, 4'd1, 8'd31, 8'd0));
    issue(fetch_word(4'd15, 4'd15, 4'd15, 8'd255, 8'd255));
    // first address past the store, then far past it
    issue(fetch_word(4'd4, 4'd1, 4'd1, 8'd0, 8'd0));
    issue(fetch_word(4'd15, 4'd1, 4'd1, 8'd0, 8'd0));
    issue(load_word(12'd0, 32'h8000_0001));
    issue(fetch_word(4'd0, 4'd1, 4'd1, 8'd0, 8'd0));
  endtask

  // mostly fetches aimed near the image so that hits, edges and range errors all occur
  function automatic gather_word_t random_word();
    gather_word_t w;
    int h;
    int wd;
    int cells;
    int lim_r;
    int lim_c;
    int chans;
    h = int'(sb.cfg.image_height);
    wd = int'(sb.cfg.image_width);
    cells = h * wd;
    w.kind = ($urandom_range(0, 99) < 70) ? WORD_FETCH : WORD_LOAD;
    w.load_address = LADDR_W'($urandom);
    w.load_value = $urandom;
    w.channel = CH_W'($urandom);
    w.kernel_row = TAP_W'($urandom);
    w.kernel_col = TAP_W'($urandom);
    w.out_row = POS_W'($urandom);
    w.out_col = POS_W'($urandom);
    if (w.kind == WORD_LOAD) begin
      if (cells > 0 && $urandom_range(0, 99) < 60)
        w.load_address = LADDR_W'($urandom_range(0, (cells >= 256) ? IMAGE_WORDS - 1
                                                                   : cells * 16 - 1));
    end else if ($urandom_range(0, 99) < 75) begin
      lim_r = (h + int'(sb.cfg.pad_rows))
            / ((sb.cfg.stride_rows == 0) ? 1 : int'(sb.cfg.stride_rows)) + 1;
      lim_c = (wd + int'(sb.cfg.pad_cols))
            / ((sb.cfg.stride_cols == 0) ? 1 : int'(sb.cfg.stride_cols)) + 1;
      w.out_row = POS_W'($urandom_range(0, (lim_r > 255) ? 255 : lim_r));
      w.out_col = POS_W'($urandom_range(0, (lim_c > 255) ? 255 : lim_c));
      if ($urandom_range(0, 1) == 1) w.kernel_row = TAP_W'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 1) w.kernel_col = TAP_W'($urandom_range(0, 3));
      chans = (cells > 0) ? IMAGE_WORDS / cells : 16;
      if (chans > 0) w.channel = CH_W'($urandom_range(0, (chans > 16) ? 15 : chans - 1));
    end
    return w;
  endfunction

  initial begin : stimulus
    iwg_cfg_t c;
    int words;
    int start;
    bit hold_done;
    bit pause_done;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < PHASES; p++) begin
      phase_plan(p, c, words);
      apply_setting(c);
      no_idle = (p == QUIET_PHASE);
      if (p == 0) run_directed();
      // fill loads count toward the phase budget
      start = sb.words_seen;
      hold_done = 1'b0;
      pause_done = 1'b0;
      while (sb.words_seen - start < words) begin
        if (p == HOLDOFF_PHASE && !hold_done && sb.words_seen - start >= 80) begin
          holdoff_request = HOLDOFF_LEN;
          hold_done = 1'b1;
        end
        if (p == PAUSE_PHASE && !pause_done && sb.words_seen - start >= words / 2) begin
          drain();
          pause_done = 1'b1;
        end
        issue(random_word());
      end
      drain();
    end
    $display("%0d words over %0d register settings, %0d fetch results checked",
             sb.words_seen, PHASES, sb.results_seen);
    $display("%0d gathered from the store, %0d padded, %0d beyond the store",
             sb.results_seen - sb.padded - sb.beyond_store, sb.padded, sb.beyond_store);
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.failures);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
